>>> rtl/core/palette_color_cycler_top_defines.svh
// ----------------------------------------------------------------------------
// Palette colour cycler assertion macros
// Shared concurrent assertion forms, clocked on clk and held off by rst_n.
// ----------------------------------------------------------------------------
`ifndef PALETTE_COLOR_CYCLER_TOP_DEFINES_SVH
`define PALETTE_COLOR_CYCLER_TOP_DEFINES_SVH

// Same-cycle implication.
`define PCC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PCC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pcc_pkg.sv
// ----------------------------------------------------------------------------
// Palette colour cycler package
// Constants, request codes and shared types of the palette colour cycler.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

    localparam int PCC_PALETTE_ENTRIES = 64;
    localparam int PCC_ROTATION_SLOTS  = 8;

    localparam int SETUP_COUNT = 8;
    localparam int SETUP_IDX_W = 3;
    localparam int SETUP_W     = 24;
    localparam int COLOR_W     = 24;
    localparam int INDEX_W     = 6;
    localparam int TIME_W      = 32;
    localparam int WAIT_W      = 12;
    localparam int SEG_W       = 9;
    localparam int MASK_W      = 8;

    localparam logic [7:0]         SLOT_OFF_MARK = 8'd255;
    localparam logic [WAIT_W-1:0]  MAX_WAIT_MS   = 12'd2550;
    localparam logic [SETUP_W-1:0] SETUP_RESET   = 24'hFF0000;

    // Request codes.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Palette RAM control strobes.
    typedef struct packed {
        logic we;
        logic re;
    } ram_ctl_t;

    // Period in 10 ms units to milliseconds, as shifts and one add.
    function automatic logic [WAIT_W-1:0] period_to_ms(input logic [7:0] period);
        logic [WAIT_W-1:0] p;
        p = {4'b0000, period};
        return (p << 3) + (p << 1);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/pcc_palette_ram.sv
// ----------------------------------------------------------------------------
// Palette RAM
// Single write port, single read port colour store with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_palette_ram
    import pcc_pkg::*;
#(
    parameter int DEPTH = PCC_PALETTE_ENTRIES
)
(
    input  wire logic                       clk,
    input  wire ram_ctl_t                   ctl,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [COLOR_W-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [COLOR_W-1:0]         rdata
);

    logic [COLOR_W-1:0] mem [DEPTH];
    logic [COLOR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/palette_color_cycler_top.sv
// ----------------------------------------------------------------------------
// Palette colour cycler
// RGB888 palette with eight timed rotation slots, driven by tick requests.
// ----------------------------------------------------------------------------
// The block takes one request at a time and holds in_stall high until it has
// finished with it. A write passes through ST_WRITE, a read through ST_READ
// and, for an index inside the palette, ST_READ_DATA; ST_FIN then loads the
// result register. A tick walks the rotation slots in order and tests each.
// For a slot that is due, the first colour of its segment is fetched, then
// the segment moves down one entry per cycle through the palette RAM (reading
// ahead while writing behind, on its separate read and write ports), and at
// the end the first colour is stored in the last entry of the segment.
// The last step of any request waits while an earlier result is still held by
// out_stall. The result sits in an output register, so the next request may be
// accepted while a result still waits to be taken.
// Slot registers are written through cfg_we, cfg_index and cfg_data, and must
// only be written while the block is idle; writing one never changes its due
// time. The palette has no reset: reading an entry that was never written
// returns whatever the RAM holds.
// ----------------------------------------------------------------------------
`default_nettype none

`include "palette_color_cycler_top_defines.svh"

module palette_color_cycler_top
    import pcc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PCC_PALETTE_ENTRIES,
    parameter int ROTATION_SLOTS  = PCC_ROTATION_SLOTS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_we,
    input  wire logic [SETUP_IDX_W-1:0] cfg_index,
    input  wire logic [SETUP_W-1:0]     cfg_data,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [1:0]             opcode,
    input  wire logic [INDEX_W-1:0]     entry_index,
    input  wire logic [COLOR_W-1:0]     entry_color,
    input  wire logic [TIME_W-1:0]      now_ms,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic      [COLOR_W-1:0]     read_color,
    output logic      [MASK_W-1:0]      rotated_mask,
    output logic      [TIME_W-1:0]      next_due_ms
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam int SW = (ROTATION_SLOTS > 1) ? $clog2(ROTATION_SLOTS) : 1;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_WRITE     = 9'b000000010,
        ST_READ      = 9'b000000100,
        ST_READ_DATA = 9'b000001000,
        ST_SLOT      = 9'b000010000,
        ST_ROT_HEAD  = 9'b000100000,
        ST_ROT_MOVE  = 9'b001000000,
        ST_ROT_TAIL  = 9'b010000000,
        ST_FIN       = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Control state.
    logic [SW-1:0]       s_reg, s_next;
    logic [7:0]          k_reg, k_next;
    logic                out_valid_reg, out_valid_next;
    logic [SETUP_W-1:0]  setup_reg [SETUP_COUNT];
    logic [TIME_W-1:0]   due_reg [ROTATION_SLOTS];
    logic [TIME_W-1:0]   due_next [ROTATION_SLOTS];

    // Request and working payload.
    logic [1:0]          opcode_reg, opcode_next;
    logic [INDEX_W-1:0]  idx_reg, idx_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [7:0]          first_reg, first_next;
    logic [7:0]          count_reg, count_next;
    logic [7:0]          period_reg, period_next;
    logic [COLOR_W-1:0]  held_reg, held_next;
    logic [COLOR_W-1:0]  rcolor_reg, rcolor_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;
    logic [WAIT_W-1:0]   best_reg, best_next;

    // Result register.
    logic [COLOR_W-1:0]  read_color_reg, read_color_next;
    logic [MASK_W-1:0]   rotated_mask_reg, rotated_mask_next;
    logic [TIME_W-1:0]   next_due_reg, next_due_next;

    // Palette RAM interface.
    ram_ctl_t            ram_ctl;
    logic [SEG_W-1:0]    waddr_full;
    logic [SEG_W-1:0]    raddr_full;
    logic [COLOR_W-1:0]  ram_wdata;
    logic [COLOR_W-1:0]  ram_rdata;

    // Slot evaluation.
    logic [SETUP_W-1:0]  setup_cur;
    logic [7:0]          cur_first;
    logic [7:0]          cur_count;
    logic [SEG_W-1:0]    cur_end;
    logic                slot_on;
    logic [TIME_W-1:0]   due_cur;
    logic [TIME_W:0]     due_diff;
    logic                slot_due;
    logic                wait_lower;
    logic                last_slot;

    // Segment addresses.
    logic [SEG_W-1:0]    seg_lo;
    logic [SEG_W-1:0]    seg_hi;
    logic [SEG_W-1:0]    idx_full;
    logic                idx_ok;
    logic                last_move;
    logic [WAIT_W-1:0]   period_ms;
    logic                accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // The slot under the scan pointer. The user must keep configuration stable while busy; it is not enforced.
    assign setup_cur = setup_reg[SETUP_IDX_W'(s_reg)];
    assign cur_first = setup_cur[23:16];
    assign cur_count = setup_cur[15:8];
    assign cur_end   = {1'b0, cur_first} + {1'b0, cur_count};
    assign slot_on   = (cur_first != SLOT_OFF_MARK) && (cur_count != 8'd0) &&
                       (cur_end <= SEG_W'(PALETTE_ENTRIES));

    // One subtractor serves both the due test and the remaining wait: a
    // borrow or a zero difference means the due time has been reached.
    assign due_cur    = due_reg[s_reg];
    assign due_diff   = {1'b0, due_cur} - {1'b0, now_reg};
    assign slot_due   = due_diff[TIME_W] || (due_diff[TIME_W-1:0] == '0);
    assign wait_lower = (due_diff[TIME_W-1:WAIT_W] == '0) &&
                        (due_diff[WAIT_W-1:0] < best_reg);
    assign last_slot  = (s_reg == SW'(ROTATION_SLOTS - 1));

    assign seg_lo    = {1'b0, first_reg};
    assign seg_hi    = {1'b0, first_reg} + {1'b0, count_reg};
    assign idx_full  = {{(SEG_W - INDEX_W){1'b0}}, idx_reg};
    assign idx_ok    = (idx_full < SEG_W'(PALETTE_ENTRIES));
    assign last_move = (k_reg == count_reg - 8'd1);
    assign period_ms = period_to_ms(period_reg);

    always_comb
    begin
        state_next        = state_reg;
        s_next            = s_reg;
        k_next            = k_reg;
        out_valid_next    = out_valid_reg;
        opcode_next       = opcode_reg;
        idx_next          = idx_reg;
        color_next        = color_reg;
        now_next          = now_reg;
        first_next        = first_reg;
        count_next        = count_reg;
        period_next       = period_reg;
        held_next         = held_reg;
        rcolor_next       = rcolor_reg;
        mask_next         = mask_reg;
        best_next         = best_reg;
        read_color_next   = read_color_reg;
        rotated_mask_next = rotated_mask_reg;
        next_due_next     = next_due_reg;
        due_next          = due_reg;
        ram_ctl           = '0;
        waddr_full        = seg_lo;
        raddr_full        = seg_lo;
        ram_wdata         = ram_rdata;

        // The result register empties when the consumer takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    opcode_next = opcode;
                    idx_next    = entry_index;
                    color_next  = entry_color;
                    now_next    = now_ms;
                    rcolor_next = '0;
                    mask_next   = '0;
                    best_next   = MAX_WAIT_MS;
                    s_next      = '0;
                    if (opcode == OP_WRITE)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (opcode == OP_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (opcode == OP_TICK)
                    begin
                        state_next = ST_SLOT;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_WRITE:
            begin
                ram_ctl.we = idx_ok;
                waddr_full = idx_full;
                ram_wdata  = color_reg;
                state_next = ST_FIN;
            end

            ST_READ:
            begin
                ram_ctl.re = idx_ok;
                raddr_full = idx_full;
                state_next = idx_ok ? ST_READ_DATA : ST_FIN;
            end

            ST_READ_DATA:
            begin
                rcolor_next = ram_rdata;
                state_next  = ST_FIN;
            end

            ST_SLOT:
            begin
                if (slot_on && slot_due)
                begin
                    first_next  = cur_first;
                    count_next  = cur_count;
                    period_next = setup_cur[7:0];
                    state_next  = ST_ROT_HEAD;
                end
                else
                begin
                    if (slot_on && wait_lower)
                    begin
                        best_next = due_diff[WAIT_W-1:0];
                    end
                    if (last_slot)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        s_next = s_reg + SW'(1);
                    end
                end
            end

            ST_ROT_HEAD:
            begin
                // Fetch the first colour of the segment; it goes to the end.
                ram_ctl.re = 1'b1;
                raddr_full = seg_lo;
                k_next     = '0;
                state_next = ST_ROT_MOVE;
            end

            ST_ROT_MOVE:
            begin
                // Each cycle but the last reads the entry after k, and each with k above zero
                // writes the one read in the previous cycle down into the place before it.
                if (k_reg == 8'd0)
                begin
                    held_next = ram_rdata;
                end
                else
                begin
                    ram_ctl.we = 1'b1;
                    waddr_full = seg_lo + {1'b0, k_reg} - SEG_W'(1);
                    ram_wdata  = ram_rdata;
                end
                if (last_move)
                begin
                    state_next = ST_ROT_TAIL;
                end
                else
                begin
                    ram_ctl.re = 1'b1;
                    raddr_full = seg_lo + {1'b0, k_reg} + SEG_W'(1);
                    k_next     = k_reg + 8'd1;
                end
            end

            ST_ROT_TAIL:
            begin
                ram_ctl.we       = 1'b1;
                waddr_full       = seg_hi - SEG_W'(1);
                ram_wdata        = held_reg;
                due_next[s_reg]  = now_reg + {{(TIME_W - WAIT_W){1'b0}}, period_ms};
                mask_next        = mask_reg | (MASK_W'(1) << s_reg);
                if (period_ms < best_reg)
                begin
                    best_next = period_ms;
                end
                if (last_slot)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    s_next     = s_reg + SW'(1);
                    state_next = ST_SLOT;
                end
            end

            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    read_color_next   = rcolor_reg;
                    rotated_mask_next = mask_reg;
                    next_due_next     = (opcode_reg == OP_TICK) ?
                                        now_reg + {{(TIME_W - WAIT_W){1'b0}}, best_reg} :
                                        '0;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SETUP_COUNT; i++)
            begin
                setup_reg[i] <= SETUP_RESET;
            end
            for (int i = 0; i < ROTATION_SLOTS; i++)
            begin
                due_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            s_reg         <= s_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            due_reg       <= due_next;
            if (cfg_we)
            begin
                setup_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        opcode_reg       <= opcode_next;
        idx_reg          <= idx_next;
        color_reg        <= color_next;
        now_reg          <= now_next;
        first_reg        <= first_next;
        count_reg        <= count_next;
        period_reg       <= period_next;
        held_reg         <= held_next;
        rcolor_reg       <= rcolor_next;
        mask_reg         <= mask_next;
        best_reg         <= best_next;
        read_color_reg   <= read_color_next;
        rotated_mask_reg <= rotated_mask_next;
        next_due_reg     <= next_due_next;
    end

    pcc_palette_ram #(
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .waddr (waddr_full[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (raddr_full[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign read_color   = read_color_reg;
    assign rotated_mask = rotated_mask_reg;
    assign next_due_ms  = next_due_reg;

    // Rotation writes must stay inside the segment being rotated.
    logic rot_wr;
    logic rot_wr_in_seg;

    assign rot_wr        = ram_ctl.we &&
                           (state_reg == ST_ROT_MOVE || state_reg == ST_ROT_TAIL);
    assign rot_wr_in_seg = (waddr_full >= seg_lo) && (waddr_full < seg_hi);

    `PCC_ASSERT_IMP(a_rot_write_in_segment, rot_wr, rot_wr_in_seg, "rotation write outside segment")
    `PCC_ASSERT_IMP(a_move_below_count, state_reg == ST_ROT_MOVE, k_reg < count_reg, "rotation step past segment end")
    `PCC_ASSERT_IMP(a_wait_capped, state_reg == ST_FIN, best_reg <= MAX_WAIT_MS, "earliest wait above cap")
    `PCC_ASSERT_IMP(a_result_from_fin, out_valid_reg && !$past(out_valid_reg), $past(state_reg == ST_FIN), "result appeared outside finish")
    `PCC_ASSERT_NEXT(a_tick_starts_scan, accept && opcode == OP_TICK, state_reg == ST_SLOT && s_reg == '0, "tick did not start slot scan")

endmodule

`default_nettype wire

>>> verif/palette_color_cycler_top_tb.sv
// ----------------------------------------------------------------------------
// Palette colour cycler testbench
// Drives write, read, tick and spare requests through the valid/stall channel,
// predicts every result with its own model of the palette and the rotation
// slots, and compares each result field by field as it leaves the block.
// ----------------------------------------------------------------------------
module palette_color_cycler_top_tb;

    import pcc_pkg::*;

    // The spare request code does nothing and must answer with an all-zero result.
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Random part: eight phases that cycle through the four idling modes.
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 102;

    // Slowest correct run: about a thousand requests, ticks with eight fully
    // overlapping 64-entry segments, and stalls on both sides. The limit is
    // meant to sit well above that.
    localparam int CYCLE_LIMIT = 3_000_000;

    // Cycles allowed after the last result for anything stray to show up.
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [1:0]         op;
        logic [INDEX_W-1:0] index;
        logic [COLOR_W-1:0] color;
        logic [TIME_W-1:0]  now;
    } request_t;

    typedef struct {
        logic [COLOR_W-1:0] color;
        logic [MASK_W-1:0]  mask;
        logic [TIME_W-1:0]  due;
    } answer_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_we      = 1'b0;
    logic [SETUP_IDX_W-1:0] cfg_index   = '0;
    logic [SETUP_W-1:0]     cfg_data    = '0;

    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic [1:0]             opcode      = OP_WRITE;
    logic [INDEX_W-1:0]     entry_index = '0;
    logic [COLOR_W-1:0]     entry_color = '0;
    logic [TIME_W-1:0]      now_ms      = '0;

    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic [COLOR_W-1:0]     read_color;
    logic [MASK_W-1:0]      rotated_mask;
    logic [TIME_W-1:0]      next_due_ms;

    palette_color_cycler_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .entry_index  (entry_index),
        .entry_color  (entry_color),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_color   (read_color),
        .rotated_mask (rotated_mask),
        .next_due_ms  (next_due_ms)
    );

    // Requests waiting to be presented, and results predicted but not yet seen.
    request_t request_queue[$];
    answer_t  answer_queue[$];
    request_t staged_req;

    // Our own copy of the block's state and slot registers.
    logic [COLOR_W-1:0] shadow_palette [PCC_PALETTE_ENTRIES];
    logic [TIME_W-1:0]  shadow_due     [PCC_ROTATION_SLOTS];
    logic [SETUP_W-1:0] shadow_setup   [SETUP_COUNT];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    logic [31:0] tick_time      = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Applies one accepted request to the shadow state and queues its result.
    // Slots are visited in order, so overlapping segments see the palette as
    // the lower-numbered slots left it.
    function automatic void apply_request(input request_t req);
        answer_t            ans;
        int                 seg_base;
        int                 seg_len;
        logic [COLOR_W-1:0] held;
        logic [TIME_W-1:0]  best;
        logic [TIME_W-1:0]  gap_ms;
        ans = '{color: '0, mask: '0, due: '0};
        case (req.op)
            OP_WRITE:
                shadow_palette[req.index] = req.color;
            OP_READ:
                ans.color = shadow_palette[req.index];
            OP_TICK:
            begin
                best = TIME_W'(MAX_WAIT_MS);
                for (int s = 0; s < PCC_ROTATION_SLOTS; s++)
                begin
                    seg_base = int'(shadow_setup[s][23:16]);
                    seg_len  = int'(shadow_setup[s][15:8]);
                    // A slot is off when marked, empty, or running past the palette.
                    if (seg_base == int'(SLOT_OFF_MARK) || seg_len == 0 ||
                        seg_base + seg_len > PCC_PALETTE_ENTRIES)
                        continue;
                    if (req.now >= shadow_due[s])
                    begin
                        held = shadow_palette[seg_base];
                        for (int k = 0; k + 1 < seg_len; k++)
                            shadow_palette[seg_base + k] = shadow_palette[seg_base + k + 1];
                        shadow_palette[seg_base + seg_len - 1] = held;
                        shadow_due[s] = req.now + TIME_W'(shadow_setup[s][7:0]) * 32'd10;
                        ans.mask[s]   = 1'b1;
                    end
                    // The distance wraps modulo 2^32, so a due time behind now is far away.
                    gap_ms = shadow_due[s] - req.now;
                    if (gap_ms < best)
                        best = gap_ms;
                end
                ans.due = req.now + best;
            end
            default:
                ;
        endcase
        answer_queue.push_back(ans);
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result();
        answer_t want;
        if (answer_queue.size() == 0)
        begin
            report_mismatch("result with no request outstanding", {8'd0, read_color}, '0);
            return;
        end
        want = answer_queue.pop_front();
        if (read_color !== want.color)
            report_mismatch("read_color", {8'd0, read_color}, {8'd0, want.color});
        if (rotated_mask !== want.mask)
            report_mismatch("rotated_mask", {24'd0, rotated_mask}, {24'd0, want.mask});
        if (next_due_ms !== want.due)
            report_mismatch("next_due_ms", next_due_ms, want.due);
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents requests from the queue, idling at random between them.
    // A stalled request is held unchanged; the decision to idle never looks at
    // the stall, only at whether the previous request has gone.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            opcode      <= OP_WRITE;
            entry_index <= '0;
            entry_color <= '0;
            now_ms      <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_request('{op: opcode, index: entry_index, color: entry_color,
                                now: now_ms});
            if (!in_valid || !in_stall)
            begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    staged_req   = request_queue.pop_front();
                    in_valid    <= 1'b1;
                    opcode      <= staged_req.op;
                    entry_index <= staged_req.index;
                    entry_color <= staged_req.color;
                    now_ms      <= staged_req.now;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: takes results, stalling at random, and checks each one taken.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [SETUP_W-1:0] pack_setup(input int seg_base, input int seg_len,
                                                      input int period);
        return {8'(seg_base), 8'(seg_len), 8'(period)};
    endfunction

    function automatic void queue_request(input logic [1:0] op, input int index,
                                          input logic [COLOR_W-1:0] color,
                                          input logic [TIME_W-1:0] now);
        request_queue.push_back('{op: op, index: INDEX_W'(index), color: color, now: now});
    endfunction

    // Slot registers may only change while the block is idle; the shadow copy
    // is updated at once, since no request can be accepted until the write lands.
    task automatic write_setup(input int slot, input logic [SETUP_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= SETUP_IDX_W'(slot);
        cfg_data  <= value;
        shadow_setup[slot] = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every queued request has been taken and every result seen.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (request_queue.size() != 0 || in_valid || answer_queue.size() != 0);
    endtask

    // Mostly short segments with short periods so that rotations are frequent,
    // with disabled and out-of-range settings and the odd long segment.
    function automatic logic [SETUP_W-1:0] random_setup();
        int pick;
        int seg_base;
        int seg_len;
        int period;
        pick = $urandom_range(99);
        if (pick < 3)
            return 24'hFFFFFF;
        if (pick < 6)
            return 24'h000000;
        if (pick < 9)
            return SETUP_RESET;
        period = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(6);
        if (pick < 13)
            return pack_setup(SLOT_OFF_MARK, $urandom_range(1, 255), period);
        if (pick < 17)
            return pack_setup($urandom_range(64, 254), $urandom_range(1, 255), period);
        seg_base = $urandom_range(PCC_PALETTE_ENTRIES - 1);
        if (pick < 22)
            return pack_setup(seg_base, PCC_PALETTE_ENTRIES - seg_base + $urandom_range(1, 8),
                              period);
        if (pick < 27)
            seg_len = $urandom_range(1, PCC_PALETTE_ENTRIES - seg_base);
        else
            seg_len = $urandom_range(1, (PCC_PALETTE_ENTRIES - seg_base < 8) ?
                                        PCC_PALETTE_ENTRIES - seg_base : 8);
        return pack_setup(seg_base, seg_len, period);
    endfunction

    // Tick times mostly advance a little, so slots fall due in turn; now and
    // then they leap, land anywhere, or sit just below the 32-bit wrap.
    function automatic logic [TIME_W-1:0] next_tick_time();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            tick_time = tick_time + $urandom_range(40);
        else if (pick < 88)
            tick_time = tick_time + $urandom_range(3000);
        else if (pick < 94)
            tick_time = $urandom();
        else
            tick_time = 32'hFFFF_FFFF - $urandom_range(100);
        return tick_time;
    endfunction

    function automatic void queue_random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 38)
            queue_request(OP_TICK, $urandom_range(63), $urandom(), next_tick_time());
        else if (pick < 68)
            queue_request(OP_READ, $urandom_range(63), $urandom(), $urandom());
        else if (pick < 95)
            queue_request(OP_WRITE, $urandom_range(63), $urandom(), $urandom());
        else
            queue_request(OP_SPARE, $urandom_range(63), $urandom(), $urandom());
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        for (int s = 0; s < SETUP_COUNT; s++)
        begin
            shadow_setup[s] = SETUP_RESET;
            shadow_due[s]   = '0;
        end
        for (int e = 0; e < PCC_PALETTE_ENTRIES; e++)
            shadow_palette[e] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Every slot is off after reset: palette extremes, ticks that rotate
        // nothing (including one at the top of the time range, where the capped
        // due time wraps), and the spare request code. Only written entries are read.
        queue_request(OP_WRITE, 0, 24'h000000, 32'h0);
        queue_request(OP_WRITE, PCC_PALETTE_ENTRIES - 1, 24'hFFFFFF, 32'hFFFF_FFFF);
        queue_request(OP_WRITE, 21, 24'hA5C35A, 32'h0);
        queue_request(OP_READ, 0, 24'hFFFFFF, 32'hFFFF_FFFF);
        queue_request(OP_READ, PCC_PALETTE_ENTRIES - 1, 24'h000000, 32'h0);
        queue_request(OP_READ, 21, 24'h0, 32'h0);
        queue_request(OP_TICK, 0, 24'h0, 32'h0000_0000);
        queue_request(OP_TICK, 0, 24'h0, 32'hFFFF_FFFF);
        queue_request(OP_SPARE, 63, 24'hFFFFFF, 32'hFFFF_FFFF);
        // Fill the whole palette so that no later read or rotation touches an
        // entry that was never written.
        for (int e = 0; e < PCC_PALETTE_ENTRIES; e++)
            queue_request(OP_WRITE, e, $urandom(), $urandom());
        wait_for_drain();

        // One setting per special case: the whole palette with period zero, a
        // single-entry segment with the longest period, the off mark, an empty
        // segment, a segment running past the palette, and overlapping segments.
        write_setup(0, pack_setup(0, PCC_PALETTE_ENTRIES, 0));
        write_setup(1, pack_setup(PCC_PALETTE_ENTRIES - 1, 1, 255));
        write_setup(2, pack_setup(10, 5, 3));
        write_setup(3, pack_setup(SLOT_OFF_MARK, 4, 1));
        write_setup(4, pack_setup(5, 0, 2));
        write_setup(5, pack_setup(60, 5, 1));
        write_setup(6, pack_setup(12, 6, 2));
        write_setup(7, pack_setup(0, 2, 1));
        queue_request(OP_TICK, 0, 24'h0, 32'd100);
        queue_request(OP_READ, 0, 24'h0, 32'h0);
        queue_request(OP_READ, 10, 24'h0, 32'h0);
        queue_request(OP_READ, PCC_PALETTE_ENTRIES - 1, 24'h0, 32'h0);
        queue_request(OP_TICK, 0, 24'h0, 32'd100);
        queue_request(OP_TICK, 0, 24'h0, 32'd125);
        queue_request(OP_WRITE, 11, 24'h123456, 32'h0);
        queue_request(OP_TICK, 0, 24'h0, 32'hFFFF_FFF0);
        queue_request(OP_TICK, 0, 24'h0, 32'd3);
        queue_request(OP_TICK, 0, 24'h0, 32'hFFFF_FFFF);
        queue_request(OP_READ, 11, 24'h0, 32'h0);
        queue_request(OP_READ, 14, 24'h0, 32'h0);
        queue_request(OP_SPARE, 0, 24'h0, 32'h0);
        // Draining here is also the pause that lets the block run dry mid-test.
        wait_for_drain();

        // Random phases. Each one reprograms some or all slots while the block is idle
        // and then runs under one of the idling modes.
        tick_time = 32'd200;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            for (int s = 0; s < SETUP_COUNT; s++)
                if (phase == 0 || $urandom_range(3) != 0)
                    write_setup(s, random_setup());
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_random_request();
            wait_for_drain();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && answer_queue.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
